/* sv/qpfi_pkg.sv */
// Shared types and constants for the Q15 polyphase FIR interpolator.
// No dependencies; imported by every RTL module of the block except the checker.
`default_nettype none
package qpfi_pkg;

  localparam int MAX_TAPS   = 512;
  localparam int MAX_FACTOR = 16;

  localparam int TAP_AW  = $clog2(MAX_TAPS);
  localparam int TAP_W   = $clog2(MAX_TAPS + 1);
  localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
  localparam int COEF_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int PROD_W  = COEF_W + SAMP_W;
  localparam int ACC_W   = PROD_W + TAP_W;
  localparam int FRAC_W  = 30;
  localparam int CNT_W   = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_TAPS   = 1'b1;

  localparam logic [FACT_W-1:0] FACTOR_RST = FACT_W'(2);
  localparam logic [TAP_W-1:0]  TAPS_RST   = TAP_W'(257);

  typedef enum logic [1:0] {
    OP_COEF   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic                     first;
    logic [TAP_AW-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SAMP_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [FACT_W-1:0] up;
    logic [TAP_W-1:0]  taps;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_PHASE,
    S_MAC,
    S_ROUND,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* sv/qpfi_cfg.sv */
// APB register file: interp_factor and tap_count, with range-clamped copies.
// Depends on qpfi_pkg.
`default_nettype none
module qpfi_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire [qpfi_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire [qpfi_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [qpfi_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  output qpfi_pkg::cfg_t                  cfg
);
  import qpfi_pkg::*;

  logic [FACT_W-1:0] factor_r, factor_nxt;
  logic [TAP_W-1:0]  taps_r, taps_nxt;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    factor_nxt = factor_r;
    taps_nxt   = taps_r;
    if (wr) begin
      case (cfg_paddr[2])
        REG_FACTOR: factor_nxt = cfg_pwdata[FACT_W-1:0];
        REG_TAPS:   taps_nxt   = cfg_pwdata[TAP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      taps_r   <= TAPS_RST;
    end else begin
      factor_r <= factor_nxt;
      taps_r   <= taps_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FACTOR: cfg_prdata = CFG_DW'(factor_r);
      REG_TAPS:   cfg_prdata = CFG_DW'(taps_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (factor_r == '0)
      cfg.up = FACT_W'(1);
    else if (factor_r > FACT_W'(MAX_FACTOR))
      cfg.up = FACT_W'(MAX_FACTOR);
    else
      cfg.up = factor_r;
    if (taps_r == '0)
      cfg.taps = TAP_W'(1);
    else if (taps_r > TAP_W'(MAX_TAPS))
      cfg.taps = TAP_W'(MAX_TAPS);
    else
      cfg.taps = taps_r;
  end

endmodule
`default_nettype wire

/* sv/qpfi_front.sv */
// Input side: accepts transfers, decodes the operation and queues work items.
// Depends on qpfi_pkg.
`default_nettype none
module qpfi_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [63:0]        in_tdata,
  input  wire  [2:0]         in_tuser,
  output qpfi_pkg::item_t    q_item,
  output logic               q_valid,
  input  wire                q_pop
);
  import qpfi_pkg::*;

  item_t      ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.op         = op_t'(in_tuser[1:0]);
    dec.first      = in_tuser[2];
    dec.coef_index = in_tdata[8:0];
    dec.coef_value = in_tdata[40:9];
    dec.sample     = in_tdata[56:41];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && (dec.op != OP_NONE);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push)
      wptr_nxt = ~wptr_r;
    if (q_pop)
      rptr_nxt = ~rptr_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      ent_r[wptr_r] <= dec;
  end

endmodule
`default_nettype wire

/* sv/qpfi_back.sv */
// Compute engine: coefficient and history memories, one shared MAC, rounding
// and the output register. Depends on qpfi_pkg.
`default_nettype none
module qpfi_back (
  input  wire              clk,
  input  wire              rst_n,
  input  qpfi_pkg::cfg_t   cfg,
  input  qpfi_pkg::item_t  q_item,
  input  wire              q_valid,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);
  import qpfi_pkg::*;

  localparam int JUP_W = CNT_W + FACT_W;
  localparam int N_W   = JUP_W + 2;

  logic signed [COEF_W-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMP_W-1:0] hist_mem [MAX_TAPS];

  state_t             state_r, state_nxt;
  logic [FACT_W-1:0]  q_r, q_nxt;
  logic [TAP_W-1:0]   k_r, k_nxt;
  logic [TAP_W-1:0]   p_r, p_nxt;
  logic               iss_r, iss_nxt;
  logic               v1_r, v2_r, hok1_r;
  logic [TAP_AW-1:0]  head_r, head_nxt;
  logic [TAP_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   scnt_r, scnt_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [JUP_W-1:0]   jup_r, jup_nxt;
  logic [JUP_W-1:0]   lim_r, lim_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               last_r, last_nxt;
  logic               eob_r, eob_nxt;
  logic [SAMP_W-1:0]  val_r, val_nxt;
  logic               sat_r, sat_nxt;
  logic               ov_r, ov_nxt;
  logic [SAMP_W-1:0]  oval_r, oval_nxt;
  logic [3:0]         oph_r, oph_nxt;
  logic               osat_r, osat_nxt;
  logic               olast_r, olast_nxt;
  logic               oeob_r, oeob_nxt;

  logic signed [COEF_W-1:0] coef_rd_r;
  logic signed [SAMP_W-1:0] hist_rd_r;
  logic signed [SAMP_W-1:0] hx;
  logic signed [PROD_W-1:0] prod_r;

  logic               coef_we, hist_we;
  logic [TAP_AW-1:0]  hist_wa;
  logic [SAMP_W-1:0]  hist_wd;

  logic               clr;
  logic [TAP_AW-1:0]  head_b;
  logic [TAP_W-1:0]   fill_b;
  logic [CNT_W-1:0]   pos_b, scnt_b;
  logic [TAP_W-1:0]   mid;
  logic [N_W-1:0]     n_w, n1_w, lim_x;
  logic               n_neg, n_over;
  logic [TAP_W:0]     k_inc;
  logic [ACC_W-1:0]   acc_adj;
  logic signed [ACC_W-FRAC_W-1:0] rnd;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  assign mid    = {1'b0, cfg.taps[TAP_W-1:1]};
  assign n_w    = {2'b00, jup_r} + N_W'(q_r) - N_W'(mid);
  assign n1_w   = n_w + N_W'(1);
  assign lim_x  = {2'b00, lim_r};
  assign n_neg  = n_w[N_W-1];
  assign n_over = !n_neg && (n_w >= lim_x);
  assign k_inc  = {1'b0, k_r} + (TAP_W+1)'(cfg.up);
  assign acc_adj = acc_r + ACC_W'(1 << (FRAC_W - 1)) - ACC_W'(acc_r[ACC_W-1]);
  assign rnd    = acc_adj[ACC_W-1:FRAC_W];

  assign clr    = (q_item.op == OP_SAMPLE) && q_item.first;
  assign head_b = clr ? '0 : head_r;
  assign fill_b = clr ? '0 : fill_r;
  assign pos_b  = clr ? '0 : pos_r;
  assign scnt_b = clr ? '0 : scnt_r;

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    iss_nxt   = iss_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    scnt_nxt  = scnt_r;
    j_nxt     = j_r;
    jup_nxt   = jup_r;
    lim_nxt   = lim_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    eob_nxt   = eob_r;
    val_nxt   = val_r;
    sat_nxt   = sat_r;
    ov_nxt    = ov_r;
    oval_nxt  = oval_r;
    oph_nxt   = oph_r;
    osat_nxt  = osat_r;
    olast_nxt = olast_r;
    oeob_nxt  = oeob_r;
    q_pop     = 1'b0;
    coef_we   = 1'b0;
    hist_we   = 1'b0;
    hist_wa   = head_b;
    hist_wd   = '0;
    if (ov_r && out_tready)
      ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_COEF) begin
            coef_we = 1'b1;
          end else begin
            hist_we   = 1'b1;
            hist_wd   = (q_item.op == OP_SAMPLE) ? q_item.sample : '0;
            head_nxt  = head_b;
            fill_nxt  = (fill_b == TAP_W'(MAX_TAPS)) ? fill_b : fill_b + TAP_W'(1);
            pos_nxt   = pos_b;
            j_nxt     = pos_b;
            scnt_nxt  = (q_item.op == OP_SAMPLE) ? sat_inc(scnt_b) : scnt_b;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        jup_nxt   = JUP_W'(j_r) * JUP_W'(cfg.up);
        lim_nxt   = JUP_W'(scnt_r) * JUP_W'(cfg.up);
        q_nxt     = '0;
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        if (q_r == cfg.up) begin
          head_nxt  = head_r + TAP_AW'(1);
          pos_nxt   = sat_inc(pos_r);
          state_nxt = S_IDLE;
        end else if (n_neg || n_over) begin
          q_nxt = q_r + FACT_W'(1);
        end else begin
          k_nxt     = TAP_W'(q_r);
          p_nxt     = '0;
          acc_nxt   = '0;
          iss_nxt   = TAP_W'(q_r) < cfg.taps;
          last_nxt  = (q_r == cfg.up - FACT_W'(1)) || (n1_w >= lim_x);
          eob_nxt   = (n1_w == lim_x);
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (iss_r) begin
          k_nxt = k_inc[TAP_W-1:0];
          p_nxt = p_r + TAP_W'(1);
          if (k_inc >= {1'b0, cfg.taps})
            iss_nxt = 1'b0;
        end
        if (v2_r)
          acc_nxt = acc_r + ACC_W'(prod_r);
        if (!iss_r && !v1_r && !v2_r)
          state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (rnd > (ACC_W-FRAC_W)'(32767)) begin
          val_nxt = 16'h7FFF;
          sat_nxt = 1'b1;
        end else if (rnd < -(ACC_W-FRAC_W)'(32768)) begin
          val_nxt = 16'h8000;
          sat_nxt = 1'b1;
        end else begin
          val_nxt = rnd[SAMP_W-1:0];
          sat_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          oval_nxt  = val_r;
          oph_nxt   = q_r[3:0];
          osat_nxt  = sat_r;
          olast_nxt = last_r;
          oeob_nxt  = eob_r;
          q_nxt     = q_r + FACT_W'(1);
          state_nxt = S_PHASE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      ov_r    <= 1'b0;
      head_r  <= '0;
      fill_r  <= '0;
      pos_r   <= '0;
      scnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      v1_r    <= (state_r == S_MAC) && iss_r;
      v2_r    <= v1_r;
      ov_r    <= ov_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      scnt_r  <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    j_r     <= j_nxt;
    jup_r   <= jup_nxt;
    lim_r   <= lim_nxt;
    acc_r   <= acc_nxt;
    last_r  <= last_nxt;
    eob_r   <= eob_nxt;
    val_r   <= val_nxt;
    sat_r   <= sat_nxt;
    oval_r  <= oval_nxt;
    oph_r   <= oph_nxt;
    osat_r  <= osat_nxt;
    olast_r <= olast_nxt;
    oeob_r  <= oeob_nxt;
    hok1_r  <= p_r < fill_r;
    prod_r  <= hx * coef_rd_r;
  end

  // entries past the fill count predate the block start and read as zero
  assign hx = hok1_r ? hist_rd_r : '0;

  always_ff @(posedge clk) begin
    if (coef_we)
      coef_mem[q_item.coef_index] <= q_item.coef_value;
    coef_rd_r <= coef_mem[k_r[TAP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hist_we)
      hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[head_r - p_r[TAP_AW-1:0]];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0000, oph_r, oval_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {oeob_r, osat_r};

endmodule
`default_nettype wire

/* sv/q15_polyphase_fir_interpolator.sv */
// Top level of the Q15 polyphase FIR interpolator.
// Depends on qpfi_pkg, qpfi_cfg, qpfi_front and qpfi_back.
//
// Upsamples a Q15 stream by interp_factor with a Q30 FIR of tap_count taps.
// A coefficient write is done by the engine without leaving its idle state.
// A sample or drain item walks the phases in turn: a produced phase passes
// its taps one after another through the single shared multiply-accumulate
// and the one read port of each memory, and a dropped phase is stepped past.
// A two-entry queue lets new items be taken while the engine works, and the
// output register holds a result while the sink stalls.
`default_nettype none
module q15_polyphase_fir_interpolator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [63:0]                  in_tdata,   // coef_index, coef_value, sample
  input  wire  [2:0]                   in_tuser,   // operation, first_of_block
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [23:0]                  out_tdata,  // value, phase
  output logic                         out_tlast,
  output logic [1:0]                   out_tuser,  // saturated, end_of_block
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [qpfi_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire  [qpfi_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [qpfi_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import qpfi_pkg::*;

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  qpfi_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qpfi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  qpfi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* sv/qpfi_checker.sv */
// Port-level checks for the interpolator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module qpfi_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire        out_tlast,
  input wire [1:0]  out_tuser,
  input wire        cfg_pready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped during stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed during stall");

  a_eob_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("block end without run end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind q15_polyphase_fir_interpolator qpfi_checker u_qpfi_checker (.*);
`default_nettype wire

/* test/q15_polyphase_fir_interpolator_test.sv */
// Self-checking testbench for q15_polyphase_fir_interpolator: directed table, then
// random blocks of sample, drain, coefficient and no-op items over several factor/tap settings.
// Depends on qpfi_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module q15_polyphase_fir_interpolator_test;
  import qpfi_pkg::*;

  localparam int SETTLE_CYCLES = 2500;
  localparam int PRELOAD_TAPS  = 64;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         phase;
    logic               sat;
    logic               last;
    logic               eob;
  } interp_out_t;

  typedef struct {
    op_t         op;
    bit          first;
    bit [8:0]    idx;
    bit [31:0]   val;
    bit [15:0]   smp;
    bit          typed;
    logic [15:0] ev;
    bit          es;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  q15_polyphase_fir_interpolator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] coef_mem [MAX_TAPS];
  logic signed [15:0] hist_mem [MAX_TAPS];
  bit [31:0] pos_cnt, samp_cnt;
  int unsigned hist_wr;
  bit [4:0] factor_reg = 5'd2;
  bit [9:0] taps_reg = 10'd257;

  interp_out_t pending_outputs[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_run = 0;
  bit calm = 1'b0;

  function automatic bit [31:0] count_up(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic void interpolate_item(op_t op, bit first, bit [8:0] idx,
                                           bit [31:0] val, bit [15:0] smp);
    int unsigned up, taps, mid, p, at;
    longint n, lim, acc, r;
    logic signed [15:0] x;
    interp_out_t o;
    int produced;
    produced = 0;
    if (op == OP_COEF) begin
      coef_mem[idx] = val;
      return;
    end
    if (op == OP_NONE) return;
    if (op == OP_SAMPLE) begin
      if (first) begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        pos_cnt = 0;
        samp_cnt = 0;
        hist_wr = 0;
      end
      x = smp;
      samp_cnt = count_up(samp_cnt);
    end else begin
      x = '0;
    end
    hist_mem[hist_wr] = x;
    up = (factor_reg < 1) ? 1 : (factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg;
    taps = (taps_reg < 1) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
    mid = taps / 2;
    lim = longint'(samp_cnt) * up;
    for (int unsigned q = 0; q < up; q++) begin
      n = longint'(pos_cnt) * up + q - mid;
      if (n < 0 || n >= lim) continue;
      acc = 0;
      p = 0;
      for (int unsigned k = q; k < taps; k += up) begin
        at = (hist_wr + MAX_TAPS - p) % MAX_TAPS;
        acc += longint'(hist_mem[at]) * longint'(coef_mem[k]);
        p++;
      end
      r = (acc >= 0) ? ((acc + (64'sd1 <<< 29)) >>> 30) : -((-acc + (64'sd1 <<< 29)) >>> 30);
      o.sat = 1'b0;
      if (r > 32767) begin
        r = 32767;
        o.sat = 1'b1;
      end
      if (r < -32768) begin
        r = -32768;
        o.sat = 1'b1;
      end
      o.value = r[15:0];
      o.phase = q[3:0];
      o.last = 1'b0;
      o.eob = (n == lim - 1);
      pending_outputs.insert(pending_outputs.size(), o);
      produced++;
    end
    if (produced > 0) pending_outputs[pending_outputs.size() - 1].last = 1'b1;
    hist_wr = (hist_wr + 1) % MAX_TAPS;
    pos_cnt = count_up(pos_cnt);
  endfunction

  always @(negedge clk) out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);

  always @(posedge clk) begin
    interp_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{value: out_tdata[15:0], phase: out_tdata[19:16], sat: out_tuser[0],
              last: out_tlast, eob: out_tuser[1]};
      results_seen++;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected output value=%0d phase=%0d sat=%0b last=%0b eob=%0b",
                 $time, got.value, got.phase, got.sat, got.last, got.eob);
      end else begin
        want = pending_outputs.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp value=%0d phase=%0d sat=%0b last=%0b eob=%0b",
                   $time, want.value, want.phase, want.sat, want.last, want.eob);
          $display("%0t:          got value=%0d phase=%0d sat=%0b last=%0b eob=%0b",
                   $time, got.value, got.phase, got.sat, got.last, got.eob);
        end
      end
    end
  end

  task automatic send_item(op_t op, bit first, bit [8:0] idx, bit [31:0] val, bit [15:0] smp);
    bit taken;
    taken = 1'b0;
    while (!calm && $urandom_range(0, 99) < 20) @(negedge clk);
    in_tuser = {first, op};
    in_tdata = {7'd0, smp, val, idx};
    in_tvalid = 1'b1;
    while (!taken) begin
      @(posedge clk);
      taken = in_tready;
      @(negedge clk);
    end
    in_tvalid = 1'b0;
    items_sent++;
    interpolate_item(op, first, idx, val, smp);
  endtask

  task automatic drain_and_settle();
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(bit reg_sel, bit [31:0] data);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = reg_sel ? CFG_AW'(4) : CFG_AW'(0);
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (reg_sel == REG_TAPS) taps_reg = data[9:0];
    else factor_reg = data[4:0];
  endtask

  function automatic bit [31:0] rand_coef();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return 32'($urandom_range(0, 33554431)) - 32'd16777216;
  endfunction

  task automatic run_block();
    int nsamp, ndrain, up;
    up = (factor_reg < 1) ? 1 : (factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg;
    nsamp = $urandom_range(1, 12);
    ndrain = ((taps_reg > MAX_TAPS ? MAX_TAPS : taps_reg) / 2) / up + $urandom_range(1, 3);
    send_item(OP_SAMPLE, 1'b1, 9'($urandom), $urandom, 16'($urandom));
    for (int i = 1; i < nsamp; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_NONE, 1'($urandom), 9'($urandom), $urandom, 16'($urandom));
          1: send_item(OP_COEF, 1'($urandom), 9'($urandom), rand_coef(), 16'($urandom));
          default: send_item(OP_DRAIN, 1'($urandom), 9'($urandom), $urandom, 16'($urandom));
        endcase
      end
      send_item(OP_SAMPLE, 1'b0, 9'($urandom), $urandom, 16'($urandom));
    end
    for (int i = 0; i < ndrain; i++)
      send_item(OP_DRAIN, 1'($urandom), 9'($urandom), $urandom, 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_item(OP_SAMPLE, 1'b0, 9'($urandom), $urandom, 16'($urandom));
  endtask

  initial begin
    stim_row_t rows[19];
    int factors[8] = '{2, 16, 0, 31, 3, 1, 5, 4};
    int tapsets[8] = '{64, 48, 0, 63, 17, 33, 7, 50};
    int start;
    rows = '{
      '{OP_COEF,   0, 0, 32'h4000_0000, 16'h0000, 0, 16'sd0, 0},
      '{OP_SAMPLE, 1, 0, 0, 16'h7FFF, 1, 16'sd32767, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h8000, 1, -16'sd32768, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h0000, 1, 16'sd0, 0},
      '{OP_COEF,   0, 0, 32'h7FFF_FFFF, 16'h0000, 0, 16'sd0, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h7FFF, 1, 16'sd32767, 1},
      '{OP_SAMPLE, 0, 0, 0, 16'h8000, 1, -16'sd32768, 1},
      '{OP_COEF,   0, 0, 32'h8000_0000, 16'h0000, 0, 16'sd0, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h8000, 1, 16'sd32767, 1},
      '{OP_SAMPLE, 0, 0, 0, 16'h0001, 1, -16'sd2, 0},
      '{OP_COEF,   0, 0, 32'h2000_0000, 16'h0000, 0, 16'sd0, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h0001, 1, 16'sd1, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'hFFFF, 1, -16'sd1, 0},
      '{OP_NONE,   1, 9'h1FF, 32'hFFFF_FFFF, 16'hFFFF, 0, 16'sd0, 0},
      '{OP_DRAIN,  1, 0, 0, 16'h1234, 0, 16'sd0, 0},
      '{OP_COEF,   1, 0, 32'h4000_0000, 16'h0000, 0, 16'sd0, 0},
      '{OP_SAMPLE, 0, 0, 0, 16'h1234, 0, 16'sd0, 0},
      '{OP_SAMPLE, 1, 0, 0, 16'h5555, 1, 16'sd21845, 0},
      '{OP_COEF,   0, 9'h1FF, 32'h0000_0001, 16'h0000, 0, 16'sd0, 0}
    };
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    pos_cnt = 0;
    samp_cnt = 0;
    hist_wr = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < PRELOAD_TAPS; i++)
      send_item(OP_COEF, 1'b0, 9'(i), rand_coef(), 16'($urandom));
    drain_and_settle();

    // unity-tap setting: every sample maps straight to one output
    cfg_write(REG_FACTOR, 32'd1);
    cfg_write(REG_TAPS, 32'd1);
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].first, rows[i].idx, rows[i].val, rows[i].smp);
      if (rows[i].typed) begin
        pending_outputs[pending_outputs.size() - 1] =
          '{value: rows[i].ev, phase: 4'd0, sat: rows[i].es, last: 1'b1, eob: 1'b1};
      end
    end
    drain_and_settle();

    foreach (factors[s]) begin
      cfg_write(REG_FACTOR, 32'(factors[s]));
      cfg_write(REG_TAPS, 32'(tapsets[s]));
      settings_run++;
      calm = (s == 5);
      start = items_sent;
      while (items_sent - start < 24) begin
        run_block();
        if (s == 1 && items_sent - start < 24) begin
          while (pending_outputs.size() != 0) @(negedge clk);
        end
      end
      calm = 1'b0;
      drain_and_settle();
    end

    $display("Sent %0d items, checked %0d outputs over %0d factor/tap settings",
             items_sent, results_seen, settings_run);
    $display("plus the directed table of rounding and clamp corners.");
    if (errors == 0) begin
      $display("q15_polyphase_fir_interpolator_test: clean");
    end else begin
      $display("q15_polyphase_fir_interpolator_test: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d outputs still expected", pending_outputs.size());
    $display("q15_polyphase_fir_interpolator_test: errors");
    $finish;
  end

endmodule

/* q15_polyphase_fir_interpolator.f */
sv/qpfi_pkg.sv
sv/qpfi_cfg.sv
sv/qpfi_front.sv
sv/qpfi_back.sv
sv/q15_polyphase_fir_interpolator.sv
sv/qpfi_checker.sv
test/q15_polyphase_fir_interpolator_test.sv
